FILE: sv/tdq_pkg.sv
package tdq_pkg;

	localparam int NUM_TIMERS = 32;
	localparam int TIME_BITS  = 48;
	localparam int ID_W       = 5;
	localparam int IDX_W      = $clog2(NUM_TIMERS);

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		KIND_SCHEDULED = 3'd0,
		KIND_FIRED     = 3'd1,
		KIND_REMOVED   = 3'd2,
		KIND_NOT_FOUND = 3'd3,
		KIND_EXPIRED   = 3'd4,
		KIND_NONE      = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_RM_WAIT,
		ST_RM_EMIT,
		ST_SCAN,
		ST_SCAN_END,
		ST_TICK_EMIT
	} state_t;

	typedef struct packed {
		op_t                  op;
		logic [ID_W-1:0]      timer_id;
		logic [TIME_BITS-1:0] now;
		logic [TIME_BITS-1:0] end_time;
		logic [TIME_BITS-1:0] period;
		logic                 repeat_req;
	} item_t;

	typedef struct packed {
		kind_t                kind;
		logic [ID_W-1:0]      fired_id;
		logic [TIME_BITS-1:0] fired_deadline;
		logic                 rescheduled;
		logic                 last;
	} result_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] deadline;
		logic [TIME_BITS-1:0] period;
		logic                 rep;
	} slot_t;

	// A zero period counts as one, and the sum saturates at the largest time.
	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] t,
		input logic [TIME_BITS-1:0] p);
		logic [TIME_BITS-1:0] pp;
		logic [TIME_BITS:0]   s;
		pp = (p == '0) ? TIME_BITS'(1) : p;
		s = {1'b0, t} + {1'b0, pp};
		return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
	endfunction

endpackage

FILE: sv/timer_deadline_queue_core.sv
// Channel  Direction  Handshake                     Word
// item     in         item_valid / item_stall       tdq_pkg::item_t
// result   out        result_valid / result_stall   tdq_pkg::result_t
//
// An add loads its result word in ST_ADD; a remove reads its slot in ST_RM_WAIT and loads
// it in ST_RM_EMIT. A tick makes one pass per result word: ST_SCAN reads each slot on the
// one read port, ST_SCAN_END does the last compare, ST_TICK_EMIT loads the word. A tick
// that finds nothing makes one pass. A new item is taken from the cycle after the last word
// is loaded. Reset clears the valid bits at once; no clearing pass. A stalled result holds
// the output register and the block waits before its next result.
module timer_deadline_queue_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  tdq_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output tdq_pkg::result_t  result
);

	localparam int N = tdq_pkg::NUM_TIMERS;
	localparam int IW = tdq_pkg::IDX_W;

	tdq_pkg::state_t  state_q, state_d;
	tdq_pkg::item_t   item_q;
	logic [N-1:0]     valid_q, valid_d;
	logic [N-1:0]     due_q, due_d;
	logic [IW-1:0]    scan_q, scan_d;
	logic             first_q, first_d;
	logic             found_q, found_d;
	logic [IW-1:0]    best_idx_q, best_idx_d;
	tdq_pkg::slot_t   best_q, best_d;

	tdq_pkg::slot_t   mem [N];
	logic [IW-1:0]    rd_addr;
	tdq_pkg::slot_t   rd_data_s1;
	logic             cmp_v_s1;
	logic [IW-1:0]    cmp_idx_s1;
	logic             scan_rd;
	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	tdq_pkg::slot_t   mem_wdata;

	logic              out_valid_q;
	tdq_pkg::result_t  out_q, out_d;
	logic              out_load;
	logic              out_free;

	logic [IW-1:0]    id_idx;
	logic             id_ok;
	logic             cand;
	logic [N-1:0]     rest;

	assign item_stall   = (state_q != tdq_pkg::ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign out_free     = !out_valid_q || !result_stall;
	assign id_idx       = item_q.timer_id[IW-1:0];
	assign id_ok        = 32'(item_q.timer_id) < N;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tdq_pkg::ST_IDLE;
			valid_q     <= '0;
			due_q       <= '0;
			scan_q      <= '0;
			first_q     <= 1'b0;
			found_q     <= 1'b0;
			cmp_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_q  <= valid_d;
			due_q    <= due_d;
			scan_q   <= scan_d;
			first_q  <= first_d;
			found_q  <= found_d;
			cmp_v_s1 <= scan_rd;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_q <= item;
		end
		if (out_load) begin
			out_q <= out_d;
		end
		best_idx_q <= best_idx_d;
		best_q     <= best_d;
		cmp_idx_s1 <= scan_q;
		rd_data_s1 <= mem[rd_addr];
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_comb begin
		state_d    = state_q;
		valid_d    = valid_q;
		due_d      = due_q;
		scan_d     = scan_q;
		first_d    = first_q;
		found_d    = found_q;
		best_idx_d = best_idx_q;
		best_d     = best_q;
		out_load   = 1'b0;
		out_d      = '0;
		mem_we     = 1'b0;
		mem_waddr  = id_idx;
		mem_wdata  = '0;
		rd_addr    = id_idx;
		scan_rd    = 1'b0;
		cand       = 1'b0;
		rest       = due_q;
		rest[best_idx_q] = 1'b0;

		// The first pass marks the due set; later passes pick among what remains of it.
		if (cmp_v_s1) begin
			cand = first_q ? (valid_q[cmp_idx_s1] && rd_data_s1.deadline <= item_q.now)
				: due_q[cmp_idx_s1];
			if (first_q) begin
				due_d[cmp_idx_s1] = cand;
			end
			if (cand && (!found_q || rd_data_s1.deadline < best_q.deadline)) begin
				found_d    = 1'b1;
				best_idx_d = cmp_idx_s1;
				best_d     = rd_data_s1;
			end
		end

		unique case (state_q)
			tdq_pkg::ST_IDLE: begin
				if (item_valid) begin
					unique case (item.op)
						tdq_pkg::OP_ADD: begin
							state_d = tdq_pkg::ST_ADD;
						end
						tdq_pkg::OP_REMOVE: begin
							state_d = tdq_pkg::ST_RM_WAIT;
						end
						tdq_pkg::OP_TICK: begin
							state_d = tdq_pkg::ST_SCAN;
							scan_d  = '0;
							first_d = 1'b1;
							found_d = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			tdq_pkg::ST_ADD: begin
				if (out_free) begin
					out_load       = 1'b1;
					out_d.fired_id = item_q.timer_id;
					out_d.last     = 1'b1;
					state_d        = tdq_pkg::ST_IDLE;
					if (!id_ok) begin
						out_d.kind = tdq_pkg::KIND_NOT_FOUND;
					end else if (item_q.end_time <= item_q.now) begin
						out_d.kind           = tdq_pkg::KIND_FIRED;
						out_d.fired_deadline = item_q.end_time;
						out_d.rescheduled    = item_q.repeat_req;
						valid_d[id_idx]      = item_q.repeat_req;
						mem_we               = item_q.repeat_req;
						mem_wdata.deadline   = tdq_pkg::sat_add(item_q.now, item_q.period);
						mem_wdata.period     = item_q.period;
						mem_wdata.rep        = 1'b1;
					end else begin
						out_d.kind           = tdq_pkg::KIND_SCHEDULED;
						out_d.fired_deadline = item_q.end_time;
						valid_d[id_idx]      = 1'b1;
						mem_we               = 1'b1;
						mem_wdata.deadline   = item_q.end_time;
						mem_wdata.period     = item_q.period;
						mem_wdata.rep        = item_q.repeat_req;
					end
				end
			end
			tdq_pkg::ST_RM_WAIT: begin
				state_d = tdq_pkg::ST_RM_EMIT;
			end
			tdq_pkg::ST_RM_EMIT: begin
				if (out_free) begin
					out_load       = 1'b1;
					out_d.fired_id = item_q.timer_id;
					out_d.last     = 1'b1;
					state_d        = tdq_pkg::ST_IDLE;
					if (id_ok && valid_q[id_idx]) begin
						out_d.kind           = tdq_pkg::KIND_REMOVED;
						out_d.fired_deadline = rd_data_s1.deadline;
						valid_d[id_idx]      = 1'b0;
					end else begin
						out_d.kind = tdq_pkg::KIND_NOT_FOUND;
					end
				end
			end
			tdq_pkg::ST_SCAN: begin
				rd_addr = scan_q;
				scan_rd = 1'b1;
				if (scan_q == IW'(N - 1)) begin
					state_d = tdq_pkg::ST_SCAN_END;
				end else begin
					scan_d = scan_q + 1'b1;
				end
			end
			tdq_pkg::ST_SCAN_END: begin
				state_d = tdq_pkg::ST_TICK_EMIT;
			end
			tdq_pkg::ST_TICK_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (!found_q) begin
						out_d.kind = tdq_pkg::KIND_NONE;
						out_d.last = 1'b1;
						state_d    = tdq_pkg::ST_IDLE;
					end else begin
						out_d.kind           = tdq_pkg::KIND_EXPIRED;
						out_d.fired_id       = tdq_pkg::ID_W'(best_idx_q);
						out_d.fired_deadline = best_q.deadline;
						out_d.rescheduled    = best_q.rep;
						out_d.last           = (rest == '0);
						due_d[best_idx_q]    = 1'b0;
						if (best_q.rep) begin
							mem_we             = 1'b1;
							mem_waddr          = best_idx_q;
							mem_wdata.deadline = tdq_pkg::sat_add(item_q.now, best_q.period);
							mem_wdata.period   = best_q.period;
							mem_wdata.rep      = 1'b1;
						end else begin
							valid_d[best_idx_q] = 1'b0;
						end
						if (rest == '0) begin
							state_d = tdq_pkg::ST_IDLE;
						end else begin
							state_d = tdq_pkg::ST_SCAN;
							scan_d  = '0;
							first_d = 1'b0;
							found_d = 1'b0;
						end
					end
				end
			end
			default: begin
				state_d = tdq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/tdq_check.sv
module tdq_check (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input tdq_pkg::item_t    item,
	input logic              result_valid,
	input logic              result_stall,
	input tdq_pkg::result_t  result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed or dropped");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != tdq_pkg::KIND_EXPIRED |-> result.last)
		else $error("single-result item without last");

	a_resched_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.rescheduled |->
			(result.kind == tdq_pkg::KIND_FIRED || result.kind == tdq_pkg::KIND_EXPIRED))
		else $error("rescheduled set on a kind that cannot fire");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.op == tdq_pkg::OP_TICK |=> item_stall)
		else $error("tick accepted but input not held off");

endmodule

bind timer_deadline_queue_core tdq_check u_tdq_check (.*);
